>>> rtl/core/lab_to_lch_converter_assert.svh
// Assertion macros for the Lab to LCh converter.
`ifndef LAB_TO_LCH_CONVERTER_ASSERT_SVH
`define LAB_TO_LCH_CONVERTER_ASSERT_SVH

// Condition must hold on every clock outside reset.
`define LCH_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define LCH_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define LCH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lch_pkg.sv
// Package: widths, constants, arc table and stage payload types for the Lab to LCh converter.
package lch_pkg;

  localparam int LIGHT_W    = 15;
  localparam int AB_W       = 16;
  localparam int CHROMA_W   = 16;
  localparam int HUE_W      = 16;
  localparam int TDATA_W    = 48;
  localparam int XY_W       = 26;
  localparam int Z_W        = 25;
  localparam int SQ_W       = 31;
  localparam int REM_W      = 32;
  localparam int ARC_W      = 21;
  localparam int TABLE_LEN  = 24;
  localparam int SQRT_STEPS = 16;
  localparam int FRAC_SHIFT = 8;

  localparam int ROTATION_STAGES_DEF = 16;

  localparam int ANGLE_HALF = 5898240;
  localparam int ANGLE_FULL = 11796480;
  localparam int HUE_ROUND  = 128;
  localparam int HUE_FULL   = 46080;

  // atan(2^-i) in 1/32768 degree
  localparam logic [ARC_W-1:0] ARC_TABLE [TABLE_LEN] = '{
    21'd1474560, 21'd870484, 21'd459940, 21'd233473, 21'd117189, 21'd58652,
    21'd29333,   21'd14667,  21'd7334,   21'd3667,   21'd1833,   21'd917,
    21'd458,     21'd229,    21'd115,    21'd57,     21'd29,     21'd14,
    21'd7,       21'd4,      21'd2,      21'd1,      21'd0,      21'd0
  };

  typedef struct packed {
    logic [LIGHT_W-1:0]     lightness;
    logic                   row_end;
    logic                   zero;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [SQ_W-1:0]        sq_a;
    logic [SQ_W-1:0]        sq_b;
  } prep_t;

  typedef struct packed {
    logic [LIGHT_W-1:0]     lightness;
    logic                   row_end;
    logic                   zero;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [REM_W-1:0]       rem;
    logic [REM_W-1:0]       root;
  } cell_t;

endpackage

>>> rtl/core/lch_prep.sv
// Input stage: squares of a and b, half-turn pre-rotation of the hue vector.
module lch_prep (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lch_pkg::LIGHT_W-1:0]   in_lightness,
  input  logic signed [lch_pkg::AB_W-1:0] in_a,
  input  logic signed [lch_pkg::AB_W-1:0] in_b,
  input  logic                          in_row_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lch_pkg::prep_t                out_data
);

  localparam int XW = lch_pkg::XY_W;
  localparam int ZW = lch_pkg::Z_W;

  logic                valid_r;
  lch_pkg::prep_t      data_r;
  lch_pkg::prep_t      data_nxt;
  logic signed [XW-1:0] x0;
  logic signed [XW-1:0] y0;
  logic signed [31:0]  pa;
  logic signed [31:0]  pb;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    x0 = XW'(in_a) <<< lch_pkg::FRAC_SHIFT;
    y0 = XW'(in_b) <<< lch_pkg::FRAC_SHIFT;
    pa = in_a * in_a;
    pb = in_b * in_b;
    data_nxt.lightness = in_lightness;
    data_nxt.row_end   = in_row_end;
    data_nxt.zero      = (in_a == '0) && (in_b == '0);
    data_nxt.sq_a      = pa[lch_pkg::SQ_W-1:0];
    data_nxt.sq_b      = pb[lch_pkg::SQ_W-1:0];
    if (in_a[lch_pkg::AB_W-1]) begin
      data_nxt.x = -x0;
      data_nxt.y = -y0;
      data_nxt.z = ZW'(lch_pkg::ANGLE_HALF);
    end else begin
      data_nxt.x = x0;
      data_nxt.y = y0;
      data_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> rtl/core/lch_cell.sv
// One chain cell: a CORDIC vectoring step and a square-root digit step, each enabled by the cell index.
module lch_cell #(
  parameter int ROTATION_STAGES = lch_pkg::ROTATION_STAGES_DEF,
  parameter int IDX             = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lch_pkg::cell_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output lch_pkg::cell_t out_data
);

  localparam int  RW        = lch_pkg::REM_W;
  localparam int  ZW        = lch_pkg::Z_W;
  localparam int  XW        = lch_pkg::XY_W;
  localparam bit  CORDIC_EN = (IDX < ROTATION_STAGES) && (IDX < lch_pkg::TABLE_LEN);
  localparam bit  SQRT_EN   = IDX < lch_pkg::SQRT_STEPS;
  localparam int  ARC_IDX   = CORDIC_EN ? IDX : 0;
  localparam int  SHIFT     = CORDIC_EN ? IDX : 0;
  localparam int  SQ_SHIFT  = SQRT_EN ? (RW - 2 - 2 * IDX) : 0;
  localparam logic [RW-1:0]        SQ_BIT = RW'(1) << SQ_SHIFT;
  localparam logic signed [ZW-1:0] ARC    = ZW'(lch_pkg::ARC_TABLE[ARC_IDX]);

  logic                 valid_r;
  lch_pkg::cell_t       data_r;
  lch_pkg::cell_t       data_nxt;
  logic signed [XW-1:0] sx;
  logic signed [XW-1:0] sy;
  logic [RW-1:0]        trial;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    data_nxt = in_data;
    sx       = in_data.x >>> SHIFT;
    sy       = in_data.y >>> SHIFT;
    trial    = in_data.root + SQ_BIT;
    if (CORDIC_EN) begin
      if (!in_data.y[XW-1]) begin
        data_nxt.x = in_data.x + sy;
        data_nxt.y = in_data.y - sx;
        data_nxt.z = in_data.z + ARC;
      end else begin
        data_nxt.x = in_data.x - sy;
        data_nxt.y = in_data.y + sx;
        data_nxt.z = in_data.z - ARC;
      end
    end
    if (SQRT_EN) begin
      if (in_data.rem >= trial) begin
        data_nxt.rem  = in_data.rem - trial;
        data_nxt.root = (in_data.root >> 1) + SQ_BIT;
      end else begin
        data_nxt.root = in_data.root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> rtl/core/lch_out.sv
// Output stage: chroma rounding, hue wrap and rounding, output register.
module lch_out (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  lch_pkg::cell_t                 in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lch_pkg::LIGHT_W-1:0]    out_lightness,
  output logic [lch_pkg::CHROMA_W-1:0]   out_chroma,
  output logic [lch_pkg::HUE_W-1:0]      out_hue,
  output logic                           out_row_end
);

  localparam int ZW = lch_pkg::Z_W;
  localparam int CW = lch_pkg::CHROMA_W;
  localparam int HW = lch_pkg::HUE_W;

  logic                          valid_r;
  logic [lch_pkg::LIGHT_W-1:0]   lightness_r;
  logic [CW-1:0]                 chroma_r;
  logic [HW-1:0]                 hue_r;
  logic                          row_end_r;
  logic [CW-1:0]                 chroma_nxt;
  logic [HW-1:0]                 hue_nxt;
  logic signed [ZW:0]            zn;
  logic signed [ZW:0]            zp;
  logic signed [ZW:0]            zsel;
  logic [HW:0]                   hq;

  assign in_ready      = !valid_r || out_ready;
  assign out_valid     = valid_r;
  assign out_lightness = lightness_r;
  assign out_chroma    = chroma_r;
  assign out_hue       = hue_r;
  assign out_row_end   = row_end_r;

  always_comb begin
    chroma_nxt = in_data.root[CW-1:0] + {{(CW-1){1'b0}}, (in_data.rem > in_data.root)};
    zn   = (ZW+1)'(in_data.z) + (ZW+1)'(lch_pkg::HUE_ROUND);
    zp   = (ZW+1)'(in_data.z) + (ZW+1)'(lch_pkg::ANGLE_FULL + lch_pkg::HUE_ROUND);
    zsel = in_data.z[ZW-1] ? zp : zn;
    hq   = zsel[lch_pkg::FRAC_SHIFT +: (HW+1)];
    if (in_data.zero || (hq >= (HW+1)'(lch_pkg::HUE_FULL))) begin
      hue_nxt = '0;
    end else begin
      hue_nxt = hq[HW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      lightness_r <= in_data.lightness;
      chroma_r    <= chroma_nxt;
      hue_r       <= hue_nxt;
      row_end_r   <= in_data.row_end;
    end
  end

endmodule

>>> rtl/core/lab_to_lch_converter.sv
// Top level: Lab to LCh pixel converter built as a chain of CORDIC/square-root cells.
//
// Usage:
//   Input stream in_*: one Lab pixel per word. in_tdata holds L (unsigned Q7.8),
//   a and b (signed Q8.8); in_tlast marks the last pixel of a row.
//   Output stream out_*: one LCh pixel per word, L copied, chroma rounded in
//   Q8.8, hue in 1/128 degree in [0, 360); out_tlast follows the pixel.
//   Pipeline: the input stage, the cell chain and the output register are
//   registered between acceptance and out_tvalid.
//   Throughput: one pixel per clock while out_tready is high. Every stage
//   has its own valid bit and takes a new word whenever it is empty or its
//   successor moves.
//   Stall: when out_tready is low the output register holds its word; earlier
//   stages keep filling until the chain is full, then in_tready drops.
//   Reset: rst_n low clears all valid bits; the chain is empty afterwards and
//   in_tready is high.
`include "lab_to_lch_converter_assert.svh"

module lab_to_lch_converter #(
  parameter int ROTATION_STAGES = lch_pkg::ROTATION_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [14:0] lightness, [30:15] green_red, [46:31] blue_yellow, [47] unused
  input  logic [lch_pkg::TDATA_W-1:0]   in_tdata,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [14:0] lightness_out, [30:15] chroma, [46:31] hue, [47] zero
  output logic [lch_pkg::TDATA_W-1:0]   out_tdata,
  output logic                          out_tlast
);

  localparam int NCELL = (ROTATION_STAGES > lch_pkg::SQRT_STEPS) ?
                         ROTATION_STAGES : lch_pkg::SQRT_STEPS;
  localparam int LW    = lch_pkg::LIGHT_W;
  localparam int ABW   = lch_pkg::AB_W;

  logic           prep_valid;
  lch_pkg::prep_t prep_data;
  logic           cvalid [NCELL+1];
  logic           cready [NCELL+1];
  lch_pkg::cell_t cdata  [NCELL+1];

  logic [LW-1:0]  lightness_out;
  logic [lch_pkg::CHROMA_W-1:0] chroma;
  logic [lch_pkg::HUE_W-1:0]    hue;

  lch_prep u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_lightness (in_tdata[LW-1:0]),
    .in_a         (in_tdata[LW +: ABW]),
    .in_b         (in_tdata[LW+ABW +: ABW]),
    .in_row_end   (in_tlast),
    .out_valid    (prep_valid),
    .out_ready    (cready[0]),
    .out_data     (prep_data)
  );

  always_comb begin
    cvalid[0]          = prep_valid;
    cdata[0].lightness = prep_data.lightness;
    cdata[0].row_end   = prep_data.row_end;
    cdata[0].zero      = prep_data.zero;
    cdata[0].x         = prep_data.x;
    cdata[0].y         = prep_data.y;
    cdata[0].z         = prep_data.z;
    cdata[0].rem       = lch_pkg::REM_W'(prep_data.sq_a) + lch_pkg::REM_W'(prep_data.sq_b);
    cdata[0].root      = '0;
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    lch_cell #(
      .ROTATION_STAGES (ROTATION_STAGES),
      .IDX             (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cvalid[i]),
      .in_ready  (cready[i]),
      .in_data   (cdata[i]),
      .out_valid (cvalid[i+1]),
      .out_ready (cready[i+1]),
      .out_data  (cdata[i+1])
    );
  end

  lch_out u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (cvalid[NCELL]),
    .in_ready      (cready[NCELL]),
    .in_data       (cdata[NCELL]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_lightness (lightness_out),
    .out_chroma    (chroma),
    .out_hue       (hue),
    .out_row_end   (out_tlast)
  );

  assign out_tdata = {1'b0, hue, chroma, lightness_out};

  `LCH_ASSERT_IMPL(a_hue_range, out_tvalid, hue < lch_pkg::HUE_FULL, "hue out of range")
  `LCH_ASSERT_IMPL(a_zero_hue, out_tvalid && (chroma == '0), hue == '0, "hue set for zero chroma")
  `LCH_ASSERT_IMPL(a_empty_ready, !out_tvalid, in_tready, "input blocked while output empty")
  `LCH_ASSERT_NEXT(a_accept_prep, in_tvalid && in_tready, prep_valid, "accepted word lost at input stage")

endmodule
